// ===== sv/anm_rle_delta_frame_decoder_defines.svh =====
// assertion helpers for the rle delta frame decoder
`ifndef ANM_RLE_DELTA_FRAME_DECODER_DEFINES_SVH
`define ANM_RLE_DELTA_FRAME_DECODER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ANM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ANM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/anm_rle_pkg.sv =====
`default_nettype none

package anm_rle_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [2:0] {
    PH_OPCODE     = 3'd0,
    PH_FILL_COUNT = 3'd1,
    PH_FILL_VALUE = 3'd2,
    PH_LITERAL    = 3'd3,
    PH_LONG_LO    = 3'd4,
    PH_LONG_HI    = 3'd5
  } phase_t;

  // one result item as held in the output register
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  length;
    logic [BYTE_W-1:0]   value;
    logic                done;
  } span_t;

endpackage

`default_nettype wire

// ===== sv/anm_rle_delta_frame_decoder.sv =====
// rle delta frame decoder
// input channel s_*: one compressed byte per item in s_tdata, s_tuser set on the
// first byte of a frame forces the parser and position back to their reset state.
// output channel m_*: one span item (offset, length, colour) for each fill and for
// each literal byte; m_tlast marks the end-of-frame item given by the stop word,
// which carries offset, length and colour of zero.
// skips, opcode bytes and zero-length spans give no output item.
// a byte accepted into the input register is parsed there combinationally and its span
// is loaded into the output register once that register is free to take it.
// throughput: one byte per cycle while the output is not stalled, set by the
// combinational parse update between the input register and the output register.
// when m_tready is low the output register holds its item; an empty input register
// still takes one more byte, then s_tready drops until the output drains.
// reset (rst, synchronous) clears both registers' valid flags, the parse phase,
// the remaining count and the write position.
// DEST_ADDR_BITS sets the position width; offsets are its low 16 bits.

`default_nettype none

`include "anm_rle_delta_frame_decoder_defines.svh"

module anm_rle_delta_frame_decoder #(
  parameter int unsigned DEST_ADDR_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output      logic                                  s_tready,
  input  wire logic [anm_rle_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] src_byte
  input  wire logic [0:0]                            s_tuser,   // [0] frame_start
  output      logic                                  m_tvalid,
  input  wire logic                                  m_tready,
  // [15:0] dest_offset, [29:16] span_length, [37:30] pixel_value, [39:38] zero
  output      logic [anm_rle_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output      logic                                  m_tlast    // frame_done
);

  localparam int unsigned P  = DEST_ADDR_BITS;
  localparam int unsigned OW = anm_rle_pkg::OFFSET_W;
  localparam int unsigned CW = anm_rle_pkg::COUNT_W;
  localparam int unsigned BW = anm_rle_pkg::BYTE_W;

  // input register
  logic          in_valid;
  logic [BW-1:0] in_byte;
  logic          in_start;

  // parser state
  anm_rle_pkg::phase_t phase, phase_next;
  logic [CW-1:0]       rem, rem_next;
  logic [P-1:0]        pos, pos_next;
  logic [BW-1:0]       lo_latch, lo_latch_next;

  // output register
  logic               out_valid;
  anm_rle_pkg::span_t out_span, out_span_next;
  logic               out_load;

  logic out_free;
  logic in_fire;

  assign out_free = !out_valid || m_tready;
  assign in_fire  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // state as seen by this item, after an optional frame restart
  anm_rle_pkg::phase_t eff_phase;
  logic [CW-1:0]       eff_rem;
  logic [P-1:0]        eff_pos;
  logic [BW-1:0]       eff_lo;

  logic [OW-1:0]       adv_n;
  logic                adv_en;
  logic [P+OW-1:0]     pos_ext;
  logic [P+OW-1:0]     pos_sum;
  logic [P+OW-1:0]     pos_wide;
  logic [OW-1:0]       word;
  logic [CW-1:0]       rem_dec;

  assign eff_phase = in_start ? anm_rle_pkg::PH_OPCODE : phase;
  assign eff_rem   = in_start ? '0 : rem;
  assign eff_pos   = in_start ? '0 : pos;
  assign eff_lo    = in_start ? '0 : lo_latch;

  assign pos_ext  = {{OW{1'b0}}, eff_pos};
  assign pos_sum  = pos_ext + {{P{1'b0}}, adv_n};
  assign pos_wide = {{OW{1'b0}}, eff_pos};
  assign word     = {in_byte, eff_lo};
  assign rem_dec  = eff_rem - CW'(1);

  always_comb begin
    phase_next    = anm_rle_pkg::PH_OPCODE;
    rem_next      = eff_rem;
    lo_latch_next = eff_lo;
    adv_en        = 1'b0;
    adv_n         = '0;
    out_load      = 1'b0;
    out_span_next = '0;
    unique case (eff_phase)
      anm_rle_pkg::PH_FILL_COUNT: begin
        rem_next   = CW'(in_byte);
        phase_next = anm_rle_pkg::PH_FILL_VALUE;
      end
      anm_rle_pkg::PH_FILL_VALUE: begin
        if (eff_rem != '0) begin
          adv_en               = 1'b1;
          adv_n                = OW'(eff_rem);
          out_load             = 1'b1;
          out_span_next.offset = pos_wide[OW-1:0];
          out_span_next.length = eff_rem;
          out_span_next.value  = in_byte;
          rem_next             = '0;
        end
      end
      anm_rle_pkg::PH_LITERAL: begin
        adv_en               = 1'b1;
        adv_n                = OW'(1);
        rem_next             = rem_dec;
        phase_next           = (rem_dec == '0) ? anm_rle_pkg::PH_OPCODE
                                               : anm_rle_pkg::PH_LITERAL;
        out_load             = 1'b1;
        out_span_next.offset = pos_wide[OW-1:0];
        out_span_next.length = CW'(1);
        out_span_next.value  = in_byte;
      end
      anm_rle_pkg::PH_LONG_LO: begin
        lo_latch_next = in_byte;
        phase_next    = anm_rle_pkg::PH_LONG_HI;
      end
      anm_rle_pkg::PH_LONG_HI: begin
        if (word == '0) begin
          // stop word: end-of-frame item and full restart
          rem_next           = '0;
          lo_latch_next      = '0;
          out_load           = 1'b1;
          out_span_next.done = 1'b1;
        end else if (!word[OW-1]) begin
          adv_en = 1'b1;
          adv_n  = word;
        end else if (word[OW-2]) begin
          rem_next   = word[CW-1:0];
          phase_next = anm_rle_pkg::PH_FILL_VALUE;
        end else begin
          rem_next = word[CW-1:0];
          if (word[CW-1:0] != '0) begin
            phase_next = anm_rle_pkg::PH_LITERAL;
          end
        end
      end
      default: begin
        // opcode byte, also taken for any unused phase code
        if (in_byte == '0) begin
          phase_next = anm_rle_pkg::PH_FILL_COUNT;
        end else if (!in_byte[BW-1]) begin
          rem_next   = CW'(in_byte);
          phase_next = anm_rle_pkg::PH_LITERAL;
        end else if (in_byte[BW-2:0] != '0) begin
          adv_en = 1'b1;
          adv_n  = OW'(in_byte[BW-2:0]);
        end else begin
          phase_next = anm_rle_pkg::PH_LONG_LO;
        end
      end
    endcase
    if (out_span_next.done) begin
      pos_next = '0;
    end else if (adv_en) begin
      pos_next = pos_sum[P-1:0];
    end else begin
      pos_next = eff_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= anm_rle_pkg::PH_OPCODE;
      rem      <= '0;
      pos      <= '0;
      lo_latch <= '0;
    end else if (in_fire) begin
      phase    <= phase_next;
      rem      <= rem_next;
      pos      <= pos_next;
      lo_latch <= lo_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_fire && out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && out_load) begin
      out_span <= out_span_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_span.done;
  assign m_tdata  = {2'b00, out_span.value, out_span.length, out_span.offset};

  `ANM_ASSERT_SAME(a_eof_item_zero, m_tvalid && m_tlast, m_tdata == '0,
                   "end-of-frame item carries non-zero span fields")
  `ANM_ASSERT_SAME(a_span_nonzero, m_tvalid && !m_tlast, out_span.length != '0,
                   "zero-length span item presented")
  `ANM_ASSERT_NEXT(a_stop_clears_pos, in_fire && out_load && out_span_next.done,
                   pos == '0 && phase == anm_rle_pkg::PH_OPCODE,
                   "stop word did not restart the parser")
  `ANM_ASSERT_NEXT(a_in_hold, in_valid && !out_free,
                   in_valid && $stable(in_byte) && $stable(in_start),
                   "input register lost a stalled item")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int POS_W          = 16;
  localparam int RANDOM_BYTES   = 420;
  localparam int NUM_DIR        = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 60;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_SPAN} row_check_t;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
  } src_item_t;

  typedef struct packed {
    logic [7:0]         b;
    logic               start;
    row_check_t         check;
    anm_rle_pkg::span_t want;
  } row_t;

  localparam anm_rle_pkg::span_t NO_SPAN = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [anm_rle_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [anm_rle_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  anm_rle_delta_frame_decoder #(.DEST_ADDR_BITS(POS_W)) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed opening: fills, literals, skips, long words, wrap, restart and stop
  row_t dir_rows [NUM_DIR] = '{
    '{8'h00, 1'b1, CHK_NONE,  NO_SPAN},
    '{8'h05, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'hAB, 1'b0, CHK_SPAN,  '{16'd0, 14'd5, 8'hAB, 1'b0}},
    '{8'h02, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'hFF, 1'b0, CHK_SPAN,  '{16'd5, 14'd1, 8'hFF, 1'b0}},
    '{8'h00, 1'b0, CHK_SPAN,  '{16'd6, 14'd1, 8'h00, 1'b0}},
    '{8'hFF, 1'b0, CHK_NONE,  NO_SPAN},
    // fill of zero pixels still eats its colour byte
    '{8'h00, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h00, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h55, 1'b0, CHK_NONE,  NO_SPAN},
    // long copy of zero bytes
    '{8'h80, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h00, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h80, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h80, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'hFF, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'hFF, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h7E, 1'b0, CHK_SPAN,  '{16'd134, 14'd16383, 8'h7E, 1'b0}},
    '{8'h80, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'hFF, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h7F, 1'b0, CHK_NONE,  NO_SPAN},
    // longest fill again, runs past the end of the buffer
    '{8'h80, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'hFF, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'hFF, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h01, 1'b0, CHK_MODEL, NO_SPAN},
    '{8'h81, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h7F, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h99, 1'b0, CHK_MODEL, NO_SPAN},
    // restart in the middle of a literal run, then stop
    '{8'h80, 1'b1, CHK_NONE,  NO_SPAN},
    '{8'h00, 1'b0, CHK_NONE,  NO_SPAN},
    '{8'h00, 1'b0, CHK_SPAN,  '{16'd0, 14'd0, 8'h00, 1'b1}}
  };

  // decoder state mirrored by the testbench
  anm_rle_pkg::phase_t dec_phase;
  logic [13:0]         dec_left;
  logic [POS_W-1:0]    dec_pos;
  logic [7:0]          dec_lo;

  src_item_t          byte_stream [$];
  anm_rle_pkg::span_t pending_spans [$];

  int err_count = 0;
  int spans_seen = 0;
  int frames_seen = 0;
  int restarts = 0;
  int idle_cycles = 0;
  int cycle_no = 0;
  int stall_left = 0;
  int stall_len;
  logic calm = 1'b0;
  anm_rle_pkg::span_t got_span;
  anm_rle_pkg::span_t want_span;

  function automatic void clear_decoder();
    dec_phase = anm_rle_pkg::PH_OPCODE;
    dec_left  = '0;
    dec_pos   = '0;
    dec_lo    = '0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output anm_rle_pkg::span_t sp);
    logic [15:0] word;
    sp = '0;
    if (start)
      clear_decoder();
    case (dec_phase)
      anm_rle_pkg::PH_FILL_COUNT: begin
        dec_left  = 14'(b);
        dec_phase = anm_rle_pkg::PH_FILL_VALUE;
        return 1'b0;
      end
      anm_rle_pkg::PH_FILL_VALUE: begin
        dec_phase = anm_rle_pkg::PH_OPCODE;
        if (dec_left == 0)
          return 1'b0;
        sp = '{16'(dec_pos), dec_left, b, 1'b0};
        dec_pos  = dec_pos + POS_W'(dec_left);
        dec_left = '0;
        return 1'b1;
      end
      anm_rle_pkg::PH_LITERAL: begin
        sp = '{16'(dec_pos), 14'd1, b, 1'b0};
        dec_pos  = dec_pos + 1'b1;
        dec_left = dec_left - 1'b1;
        if (dec_left == 0)
          dec_phase = anm_rle_pkg::PH_OPCODE;
        return 1'b1;
      end
      anm_rle_pkg::PH_LONG_LO: begin
        dec_lo    = b;
        dec_phase = anm_rle_pkg::PH_LONG_HI;
        return 1'b0;
      end
      anm_rle_pkg::PH_LONG_HI: begin
        word = {b, dec_lo};
        dec_phase = anm_rle_pkg::PH_OPCODE;
        if (word == 0) begin
          clear_decoder();
          sp.done = 1'b1;
          return 1'b1;
        end
        if (!word[15]) begin
          dec_pos = dec_pos + POS_W'(word);
        end else if (word[14]) begin
          dec_left  = word[13:0];
          dec_phase = anm_rle_pkg::PH_FILL_VALUE;
        end else begin
          dec_left = word[13:0];
          if (dec_left != 0)
            dec_phase = anm_rle_pkg::PH_LITERAL;
        end
        return 1'b0;
      end
      default: begin
        dec_phase = anm_rle_pkg::PH_OPCODE;
        if (b == 0) begin
          dec_phase = anm_rle_pkg::PH_FILL_COUNT;
        end else if (!b[7]) begin
          dec_left  = 14'(b);
          dec_phase = anm_rle_pkg::PH_LITERAL;
        end else if (b[6:0] != 0) begin
          dec_pos = dec_pos + POS_W'(b[6:0]);
        end else begin
          dec_phase = anm_rle_pkg::PH_LONG_LO;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic start);
    anm_rle_pkg::span_t sp;
    if (decode_byte(b, start, sp))
      pending_spans.push_back(sp);
    byte_stream.push_back('{b, start});
    if (start)
      restarts++;
  endfunction

  // rare restart in the middle of a sequence
  function automatic logic brk();
    return $urandom_range(0, 99) == 0;
  endfunction

  function automatic void add_long(input logic [15:0] w, input logic start);
    add_byte(8'h80, start);
    add_byte(w[7:0], brk());
    add_byte(w[15:8], brk());
  endfunction

  // mostly well-formed opcode sequences with random content, some noise
  function automatic void add_random_sequence();
    int kind;
    int n;
    logic [15:0] w;
    logic st;
    kind = $urandom_range(0, 99);
    st = ($urandom_range(0, 31) == 0);
    if (kind < 20) begin
      n = $urandom_range(0, 9);
      add_byte(8'h00, st);
      add_byte(n == 0 ? 8'd0 : n == 1 ? 8'd255 : 8'($urandom_range(1, 16)), brk());
      add_byte(8'($urandom), brk());
    end else if (kind < 45) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 127) : $urandom_range(1, 6);
      add_byte(8'(n), st);
      repeat (n) add_byte(8'($urandom), brk());
    end else if (kind < 60) begin
      add_byte(8'($urandom_range(8'h81, 8'hFF)), st);
    end else if (kind < 70) begin
      w = $urandom_range(0, 1) ? 16'($urandom_range(1, 255)) : 16'($urandom_range(1, 16'h7FFF));
      add_long(w, st);
    end else if (kind < 80) begin
      n = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 16383);
      add_long(16'hC000 | 16'(n), st);
      add_byte(8'($urandom), brk());
    end else if (kind < 88) begin
      n = $urandom_range(0, 5);
      add_long(16'h8000 | 16'(n), st);
      repeat (n) add_byte(8'($urandom), brk());
    end else if (kind < 94) begin
      add_long(16'h0000, st);
    end else begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom), $urandom_range(0, 9) == 0);
    end
  endfunction

  // mostly short gaps, a few long ones, none while calm
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic flag_mismatch(input string what, input longint got_v, input longint want_v);
    if (err_count < MAX_PRINTS)
      $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
               spans_seen, what, got_v, want_v);
    err_count++;
  endtask

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    calm <= (cycle_no % 1500) >= 1200;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      stall_len = gap_len();
      m_tready <= (stall_len == 0);
      if (stall_len != 0)
        stall_left <= stall_len - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_span = '{m_tdata[15:0], m_tdata[29:16], m_tdata[37:30], m_tlast};
      if (pending_spans.size() == 0) begin
        flag_mismatch("item with nothing expected", got_span, 0);
      end else begin
        want_span = pending_spans.pop_front();
        if (got_span.offset !== want_span.offset)
          flag_mismatch("dest_offset", got_span.offset, want_span.offset);
        if (got_span.length !== want_span.length)
          flag_mismatch("span_length", got_span.length, want_span.length);
        if (got_span.value !== want_span.value)
          flag_mismatch("pixel_value", got_span.value, want_span.value);
        if (got_span.done !== want_span.done)
          flag_mismatch("frame_done", got_span.done, want_span.done);
      end
      if (m_tlast)
        frames_seen++;
      spans_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no progress for %0d cycles, %0d results outstanding",
               idle_cycles, pending_spans.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    anm_rle_pkg::span_t sp;
    clear_decoder();
    foreach (dir_rows[i]) begin
      byte_stream.push_back('{dir_rows[i].b, dir_rows[i].start});
      if (dir_rows[i].start)
        restarts++;
      if (decode_byte(dir_rows[i].b, dir_rows[i].start, sp) && dir_rows[i].check == CHK_MODEL)
        pending_spans.push_back(sp);
      if (dir_rows[i].check == CHK_SPAN)
        pending_spans.push_back(dir_rows[i].want);
    end
    while (byte_stream.size() < NUM_DIR + RANDOM_BYTES)
      add_random_sequence();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (byte_stream[k]) begin
      gap = gap_len();
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= byte_stream[k].b;
      s_tuser  <= byte_stream[k].start;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;

    while (pending_spans.size() != 0) @(posedge clk);
    // a stray extra item would show up within the pipeline latency plus a long stall
    repeat (50) @(posedge clk);

    $display("fed %0d compressed bytes (%0d directed), %0d with frame restart",
             byte_stream.size(), NUM_DIR, restarts);
    $display("checked %0d output items, %0d of them end of frame, %0d mismatches",
             spans_seen, frames_seen, err_count);
    if (err_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
